// ===== rtl/dsa_pkg.sv =====
// dsa_pkg: shared constants, command and status types for decimal_scale_align.
// Used by dsa_ctrl, dsa_dpath and the decimal_scale_align top level.
package dsa_pkg;

  localparam int MANTISSA_BITS_DEF = 96;
  localparam int MAX_SCALE_DEF     = 28;

  // Port widths fixed by the interface
  localparam int SCALE_W = 5;
  localparam int LOW_W   = 64;
  localparam int HIGH_W  = 32;
  localparam int PORT_W  = LOW_W + HIGH_W;

  // Divide-by-ten unit works on one 16-bit chunk per cycle.
  // 2^16 = 10 * CHUNK_Q + CHUNK_R
  localparam int CHUNK_W   = 16;
  localparam int CHUNK_Q   = 6553;
  localparam int CHUNK_R   = 6;
  // floor(t / 10) = (t * DIV_RECIP) >> DIV_SHIFT for t below 2^18
  localparam int DIV_RECIP = 52429;
  localparam int DIV_SHIFT = 19;
  localparam int TEN       = 10;
  localparam int HALF_DIG  = 5;

  typedef struct packed {
    logic load;        // capture an input item
    logic mul_step;    // working value times ten
    logic mul_commit;  // small operand takes the scaled value and the big scale
    logic dv_load;     // copy big mantissa into the divider, clear remainder
    logic dv_chunk;    // one 16-bit chunk of the division
    logic dv_round;    // round half to even, write back big mantissa
    logic dv_fin;      // big operand takes the small scale, fix sign of zero
    logic publish;     // move result into the output register
  } dsa_cmd_t;

  typedef struct packed {
    logic [SCALE_W-1:0] diff;     // big scale minus small scale
    logic               mul_ovf;  // next times-ten would overflow
    logic               bg_zero;  // big mantissa is zero
    logic               out_free; // output register can take a result
  } dsa_stat_t;

endpackage

// ===== rtl/dsa_ctrl.sv =====
// dsa_ctrl: sequencer for scale alignment (multiply tries, then digit cuts).
// Depends on dsa_pkg; drives dsa_dpath through dsa_cmd_t, reads dsa_stat_t.
module dsa_ctrl
  import dsa_pkg::*;
#(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dsa_stat_t st,
  output dsa_cmd_t  cmd
);

  localparam int NCHUNK = (MANTISSA_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DV_CHK = 3'd3;
  localparam logic [2:0] S_DV_CH  = 3'd4;
  localparam logic [2:0] S_DV_RND = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [SCALE_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]      chk_r, chk_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    chk_nxt   = chk_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cnt_nxt   = st.diff;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (cnt_r == '0) begin
          cmd.mul_commit = 1'b1;
          state_nxt      = S_FIN;
        end else if (st.mul_ovf) begin
          // abandon scaling up, cut the big operand instead
          cnt_nxt   = st.diff;
          state_nxt = S_DV_CHK;
        end else begin
          cmd.mul_step = 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
        end
      end
      S_DV_CHK: begin
        if (cnt_r == '0 || st.bg_zero) begin
          cmd.dv_fin = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.dv_load = 1'b1;
          chk_nxt     = '0;
          state_nxt   = S_DV_CH;
        end
      end
      S_DV_CH: begin
        cmd.dv_chunk = 1'b1;
        chk_nxt      = chk_r + 1'b1;
        if (chk_r == CW'(NCHUNK - 1)) state_nxt = S_DV_RND;
      end
      S_DV_RND: begin
        cmd.dv_round = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        state_nxt    = S_DV_CHK;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      chk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chk_r   <= chk_nxt;
    end
  end

endmodule

// ===== rtl/dsa_dpath.sv =====
// dsa_dpath: operand registers, times-ten unit, chunked divide-by-ten with
// half-even rounding, and the output register. Depends on dsa_pkg.
module dsa_dpath
  import dsa_pkg::*;
#(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dsa_cmd_t           cmd,
  output dsa_stat_t          st,
  input  logic [LOW_W-1:0]   in_a_mant_low,
  input  logic [HIGH_W-1:0]  in_a_mant_high,
  input  logic [SCALE_W-1:0] in_a_scale_in,
  input  logic               in_a_neg_in,
  input  logic [LOW_W-1:0]   in_b_mant_low,
  input  logic [HIGH_W-1:0]  in_b_mant_high,
  input  logic [SCALE_W-1:0] in_b_scale_in,
  input  logic               in_b_neg_in,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [LOW_W-1:0]   out_a_res_low,
  output logic [HIGH_W-1:0]  out_a_res_high,
  output logic [SCALE_W-1:0] out_a_scale_out,
  output logic               out_a_neg_out,
  output logic [LOW_W-1:0]   out_b_res_low,
  output logic [HIGH_W-1:0]  out_b_res_high,
  output logic [SCALE_W-1:0] out_b_scale_out,
  output logic               out_b_neg_out
);

  localparam int MB     = MANTISSA_BITS;
  localparam int NCHUNK = (MB + CHUNK_W - 1) / CHUNK_W;
  localparam int W      = NCHUNK * CHUNK_W;
  localparam int EW     = (MB > PORT_W) ? MB : PORT_W;

  // operand registers, small = smaller scale
  logic [MB-1:0]      sm_mant_r, bg_mant_r;
  logic [SCALE_W-1:0] sm_scale_r, bg_scale_r;
  logic               sm_neg_r, bg_neg_r, a_small_r;
  logic [W-1:0]       tmp_r;
  logic [3:0]         rem_r;

  // output register
  logic               out_valid_r;
  logic [MB-1:0]      oa_mant_r, ob_mant_r;
  logic [SCALE_W-1:0] oa_scale_r, ob_scale_r;
  logic               oa_neg_r, ob_neg_r;

  // input capture: mask to MB bits, saturate scale
  logic [EW-1:0]      a_ext, b_ext;
  logic [MB-1:0]      a_m, b_m;
  logic [SCALE_W-1:0] a_s, b_s;
  logic               a_lt;

  assign a_ext = EW'({in_a_mant_high, in_a_mant_low});
  assign b_ext = EW'({in_b_mant_high, in_b_mant_low});
  assign a_m   = a_ext[MB-1:0];
  assign b_m   = b_ext[MB-1:0];
  assign a_s   = (int'(in_a_scale_in) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : in_a_scale_in;
  assign b_s   = (int'(in_b_scale_in) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : in_b_scale_in;
  assign a_lt  = (a_s < b_s);

  // times ten as 8x + 2x
  logic [MB+3:0] prod;
  assign prod = ({4'b0, tmp_r[MB-1:0]} << 3) + ({4'b0, tmp_r[MB-1:0]} << 1);

  // one chunk of long division: v = rem * 2^16 + c
  logic [CHUNK_W-1:0] dv_top, dv_q;
  logic [16:0]        dv_t, dv_tq;
  logic [33:0]        dv_p;
  logic [3:0]         dv_rem;

  assign dv_top = tmp_r[W-1 -: CHUNK_W];
  assign dv_t   = 17'(rem_r) * 17'(CHUNK_R) + 17'(dv_top);
  assign dv_p   = 34'(dv_t) * 34'(DIV_RECIP);
  assign dv_tq  = 17'(dv_p >> DIV_SHIFT);
  assign dv_rem = 4'(dv_t - dv_tq * 17'(TEN));
  assign dv_q   = CHUNK_W'(rem_r) * CHUNK_W'(CHUNK_Q) + CHUNK_W'(dv_tq);

  // half-even rounding on the dropped digit
  logic [MB-1:0] quo, quo_rnd;
  logic          inc;
  assign quo     = tmp_r[MB-1:0];
  assign inc     = (rem_r > 4'(HALF_DIG)) || (rem_r == 4'(HALF_DIG) && quo[0]);
  assign quo_rnd = quo + MB'(inc);

  assign st.diff     = bg_scale_r - sm_scale_r;
  assign st.mul_ovf  = |prod[MB+3:MB];
  assign st.bg_zero  = (bg_mant_r == '0);
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_small_r <= a_lt;
      if (a_lt) begin
        sm_mant_r  <= a_m;
        sm_scale_r <= a_s;
        sm_neg_r   <= in_a_neg_in;
        bg_mant_r  <= b_m;
        bg_scale_r <= b_s;
        bg_neg_r   <= in_b_neg_in;
        tmp_r      <= W'(a_m);
      end else begin
        sm_mant_r  <= b_m;
        sm_scale_r <= b_s;
        sm_neg_r   <= in_b_neg_in;
        bg_mant_r  <= a_m;
        bg_scale_r <= a_s;
        bg_neg_r   <= in_a_neg_in;
        tmp_r      <= W'(b_m);
      end
    end
    if (cmd.mul_step) tmp_r <= W'(prod[MB-1:0]);
    if (cmd.mul_commit) begin
      sm_mant_r  <= tmp_r[MB-1:0];
      sm_scale_r <= bg_scale_r;
    end
    if (cmd.dv_load) begin
      tmp_r <= W'(bg_mant_r);
      rem_r <= '0;
    end
    if (cmd.dv_chunk) begin
      tmp_r <= {tmp_r[W-CHUNK_W-1:0], dv_q};
      rem_r <= dv_rem;
    end
    if (cmd.dv_round) bg_mant_r <= quo_rnd;
    if (cmd.dv_fin) begin
      bg_scale_r <= sm_scale_r;
      if (bg_mant_r == '0) bg_neg_r <= 1'b0;
    end
    if (cmd.publish) begin
      oa_mant_r  <= a_small_r ? sm_mant_r  : bg_mant_r;
      oa_scale_r <= a_small_r ? sm_scale_r : bg_scale_r;
      oa_neg_r   <= a_small_r ? sm_neg_r   : bg_neg_r;
      ob_mant_r  <= a_small_r ? bg_mant_r  : sm_mant_r;
      ob_scale_r <= a_small_r ? bg_scale_r : sm_scale_r;
      ob_neg_r   <= a_small_r ? bg_neg_r   : sm_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [EW-1:0] oa_ext, ob_ext;
  assign oa_ext = EW'(oa_mant_r);
  assign ob_ext = EW'(ob_mant_r);

  assign out_valid       = out_valid_r;
  assign out_a_res_low   = oa_ext[LOW_W-1:0];
  assign out_a_res_high  = oa_ext[PORT_W-1:LOW_W];
  assign out_a_scale_out = oa_scale_r;
  assign out_a_neg_out   = oa_neg_r;
  assign out_b_res_low   = ob_ext[LOW_W-1:0];
  assign out_b_res_high  = ob_ext[PORT_W-1:LOW_W];
  assign out_b_scale_out = ob_scale_r;
  assign out_b_neg_out   = ob_neg_r;

endmodule

// ===== rtl/decimal_scale_align.sv =====
// decimal_scale_align: top level, aligns two sign-magnitude decimals to one scale.
// Depends on dsa_pkg; instantiates dsa_ctrl (sequencer) and dsa_dpath (datapath).
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+-------------------
//  input   | in_a_*, in_b_* (mantissa, scale, sign)  | in        | in_valid/in_ready
//  result  | out_a_*, out_b_* (mantissa, scale, sign)| out       | out_valid/out_ready
//
// One item is in work at a time. With equal scales the item passes the setup,
// multiply and finish states, and in_ready rises with out_valid. With scale difference d
// the small operand takes d times-ten steps when every step fits; when a step overflows
// (at most d - 1 good tries) the big operand is cut instead: each cut digit goes
// through load, NCHUNK chunks at one 16-bit chunk per cycle through the divide-by-ten
// unit, and round, NCHUNK = 6 for 96-bit mantissas. A cut stops early at zero.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the
// output register. A stalled result sits in the output register; the next item
// is accepted meanwhile and waits finished until that register is taken.
module decimal_scale_align
  import dsa_pkg::*;
#(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LOW_W-1:0]   in_a_mant_low,
  input  logic [HIGH_W-1:0]  in_a_mant_high,
  input  logic [SCALE_W-1:0] in_a_scale_in,
  input  logic               in_a_neg_in,
  input  logic [LOW_W-1:0]   in_b_mant_low,
  input  logic [HIGH_W-1:0]  in_b_mant_high,
  input  logic [SCALE_W-1:0] in_b_scale_in,
  input  logic               in_b_neg_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LOW_W-1:0]   out_a_res_low,
  output logic [HIGH_W-1:0]  out_a_res_high,
  output logic [SCALE_W-1:0] out_a_scale_out,
  output logic               out_a_neg_out,
  output logic [LOW_W-1:0]   out_b_res_low,
  output logic [HIGH_W-1:0]  out_b_res_high,
  output logic [SCALE_W-1:0] out_b_scale_out,
  output logic               out_b_neg_out
);

  dsa_cmd_t  cmd;
  dsa_stat_t st;

  // sequencer: try scaling the small operand up, fall back to cutting the big one
  dsa_ctrl #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: operand registers, arithmetic units and the output register
  dsa_dpath #(
    .MANTISSA_BITS (MANTISSA_BITS),
    .MAX_SCALE     (MAX_SCALE)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_a_mant_low   (in_a_mant_low),
    .in_a_mant_high  (in_a_mant_high),
    .in_a_scale_in   (in_a_scale_in),
    .in_a_neg_in     (in_a_neg_in),
    .in_b_mant_low   (in_b_mant_low),
    .in_b_mant_high  (in_b_mant_high),
    .in_b_scale_in   (in_b_scale_in),
    .in_b_neg_in     (in_b_neg_in),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_a_res_low   (out_a_res_low),
    .out_a_res_high  (out_a_res_high),
    .out_a_scale_out (out_a_scale_out),
    .out_a_neg_out   (out_a_neg_out),
    .out_b_res_low   (out_b_res_low),
    .out_b_res_high  (out_b_res_high),
    .out_b_scale_out (out_b_scale_out),
    .out_b_neg_out   (out_b_neg_out)
  );

endmodule
